/* design/e2lp_pkg.sv */
// Package for the ext2 layout planner: defaults, status codes, state type, sparse copy test.
// No dependencies.
package e2lp_pkg;
   localparam int unsigned BlocksPerGroupDef = 8192;
   localparam int unsigned InodeBytesDef     = 128;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_SMALL = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_DIVG  = 7'b0000010,
      ST_DIVI  = 7'b0000100,
      ST_TRIM  = 7'b0001000,
      ST_SUM   = 7'b0010000,
      ST_FIN   = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   // sparse superblock copy: 0, 1, powers of 3, 5, 7 (up to 2^22)
   function automatic logic has_copy(input logic [21:0] g);
      logic r;
      logic [47:0] p3, p5, p7;
      r  = (g <= 22'd1);
      p3 = 48'd3;
      p5 = 48'd5;
      p7 = 48'd7;
      for (int k = 0; k < 14; k++) begin
         if (p3 == {26'd0, g} || p5 == {26'd0, g} || p7 == {26'd0, g}) r = 1'b1;
         p3 = 48'(p3 * 48'd3);
         p5 = 48'(p5 * 48'd5);
         p7 = 48'(p7 * 48'd7);
      end
      return r;
   endfunction
endpackage

/* design/ext2_layout_planner_core.sv */
// Top level of the ext2 layout planner: sequencer, divider and metadata adder.
// Depends on e2lp_pkg and e2lp_divider.
//
// One word per start: busy rises the next cycle and stays high while the word
// is planned: a state that sizes the group count, a division for the inodes per
// group, one trimming test per trailing group dropped plus the one that stops,
// the metadata sum over the groups left after trimming (at most 262144), which
// dominates, and the finish and output states. A volume under 64 blocks goes
// straight to the output state. The result appears for one cycle with rsp_valid
// in the first cycle that busy is low, when the next start may already be
// taken, and cannot be held off.
module ext2_layout_planner_core #(
   parameter int unsigned BLOCKS_PER_GROUP = e2lp_pkg::BlocksPerGroupDef,
   parameter int unsigned INODE_BYTES      = e2lp_pkg::InodeBytesDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_sector_count,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [30:0] rsp_total_blocks,
   output logic [18:0] rsp_group_count,
   output logic [13:0] rsp_inodes_per_group,
   output logic [10:0] rsp_inode_table_blocks,
   output logic [13:0] rsp_descriptor_table_blocks,
   output logic [31:0] rsp_total_inodes,
   output logic [30:0] rsp_free_blocks,
   output logic [26:0] rsp_reserved_blocks
);
   localparam logic [31:0] Bpg = 32'(BLOCKS_PER_GROUP);
   localparam logic [31:0] Ib  = 32'(INODE_BYTES);
   localparam int unsigned BpgLog = $clog2(BLOCKS_PER_GROUP);
   // reciprocal of the group size, exact for any 32-bit dividend
   localparam logic [32:0] BpgRecip =
      33'(((65'd1 << (32 + BpgLog)) + 65'(Bpg) - 65'd1) / 65'(Bpg));

   e2lp_pkg::state_type st_ff, st_in;
   logic [31:0] blk_ff, blk_in;
   logic [21:0] grp_ff, grp_in;
   logic [13:0] ipg_ff, ipg_in;
   logic [40:0] used_ff, used_in;
   logic [21:0] i_ff, i_in;
   logic        out_ff, out_in;
   logic [1:0]  stat_ff, stat_in;
   logic [26:0] rsv_ff, rsv_in;

   logic        dgo, ddone;
   logic [31:0] dnum, dden, dq;

   e2lp_divider u_div (
      .clock(clock), .reset(reset), .go(dgo), .dividend(dnum), .divisor(dden),
      .done(ddone), .quotient(dq)
   );

   logic [31:0] ipg_up;
   logic [21:0] itab;
   logic [18:0] gdt;
   logic [31:0] first, rest, glen;
   logic [41:0] cost_last, cost_i;
   logic [31:0] groups_div;
   logic [21:0] grp_q;
   logic [31:0] inodes;

   always_comb begin
      itab = 22'((32'(ipg_ff) * Ib + 32'd1023) >> 10);
      gdt  = 19'(({10'd0, grp_ff} * 32'd32 + 32'd1023) >> 10);
      first = 32'(33'd1 + 33'(grp_ff - 22'd1) * 33'(Bpg));
      rest  = (blk_ff > first) ? blk_ff - first : 32'd0;
      glen  = (rest > Bpg) ? Bpg : rest;
      cost_last = 42'd3 + 42'(itab) +
                  (e2lp_pkg::has_copy(grp_ff - 22'd1) ? 42'd1 + 42'(gdt) : 42'd0);
      cost_i = 42'd2 + 42'(itab) +
               (e2lp_pkg::has_copy(i_ff) ? 42'd1 + 42'(gdt) : 42'd0);
      groups_div = (32'(blk_ff - 32'd1) + Bpg - 32'd1);
      grp_q = 22'((65'(groups_div) * 65'(BpgRecip)) >> (32 + BpgLog));
      inodes = ((blk_ff >> 4) < 32'd12) ? 32'd12 : (blk_ff >> 4);
      ipg_up = ((dq + 32'd7) >> 3) << 3;
   end

   always_comb begin
      st_in = st_ff; blk_in = blk_ff; grp_in = grp_ff; ipg_in = ipg_ff;
      used_in = used_ff; i_in = i_ff; out_in = 1'b0; stat_in = stat_ff;
      rsv_in = rsv_ff;
      dgo = 1'b0; dnum = inodes; dden = 32'(grp_q);
      unique case (st_ff)
         e2lp_pkg::ST_IDLE: begin
            if (start) begin
               blk_in = {1'b0, req_sector_count[31:1]};
               if (req_sector_count[31:1] < 31'd64) begin
                  stat_in = e2lp_pkg::STAT_SMALL;
                  st_in = e2lp_pkg::ST_OUT;
               end else begin
                  st_in = e2lp_pkg::ST_DIVG;
               end
            end
         end
         e2lp_pkg::ST_DIVG: begin
            grp_in = grp_q;
            dgo = 1'b1;
            st_in = e2lp_pkg::ST_DIVI;
         end
         e2lp_pkg::ST_DIVI: begin
            if (ddone) begin
               // round up the division, then to eight
               ipg_in = (ipg_up > 32'd8184 || 32'(dq * 32'(grp_ff)) < inodes &&
                         ipg_up == 32'd8192) ? 14'd8192 : 14'(ipg_up);
               if (32'(dq * 32'(grp_ff)) < inodes) begin
                  ipg_in = (((dq + 32'd8) >> 3) << 3) > 32'd8192 ? 14'd8192 :
                           14'(((dq + 32'd8) >> 3) << 3);
               end else if (ipg_up > 32'd8192) begin
                  ipg_in = 14'd8192;
               end
               if (ipg_in < 14'd16) ipg_in = 14'd16;
               st_in = e2lp_pkg::ST_TRIM;
            end
         end
         e2lp_pkg::ST_TRIM: begin
            if (grp_ff > 22'd1 && 42'(glen) <= cost_last) begin
               grp_in = grp_ff - 22'd1;
               blk_in = 32'(33'd1 + 33'(grp_ff - 22'd1) * 33'(Bpg));
            end else begin
               used_in = 41'd2; i_in = '0;
               st_in = e2lp_pkg::ST_SUM;
            end
         end
         e2lp_pkg::ST_SUM: begin
            // accumulate one group per cycle
            used_in = 41'(42'(used_ff) + cost_i);
            i_in = i_ff + 22'd1;
            if (i_ff == grp_ff - 22'd1) st_in = e2lp_pkg::ST_FIN;
         end
         e2lp_pkg::ST_FIN: begin
            stat_in = (used_ff + 41'd8 >= 41'(blk_ff)) ? e2lp_pkg::STAT_FULL :
                      e2lp_pkg::STAT_OK;
            // divide by twenty: drop two bits, then multiply by the reciprocal of five
            rsv_in = 27'((64'(blk_ff[31:2]) * 64'hCCCCCCCD) >> 34);
            st_in = e2lp_pkg::ST_OUT;
         end
         e2lp_pkg::ST_OUT: begin
            out_in = 1'b1;
            st_in = e2lp_pkg::ST_IDLE;
         end
         default: st_in = e2lp_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in; grp_ff <= grp_in; ipg_ff <= ipg_in;
      used_ff <= used_in; i_ff <= i_in; stat_ff <= stat_in;
      rsv_ff <= rsv_in;
      if (reset) begin
         st_ff <= e2lp_pkg::ST_IDLE;
         out_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         out_ff <= out_in;
      end
   end

   logic ok;
   logic [31:0] tot;
   assign ok = out_ff && stat_ff == e2lp_pkg::STAT_OK;
   assign tot = 32'(32'(ipg_ff) * 32'(grp_ff));
   assign busy = st_ff != e2lp_pkg::ST_IDLE;
   assign rsp_valid = out_ff;
   assign rsp_status = stat_ff;
   assign rsp_total_blocks = ok ? blk_ff[30:0] : '0;
   assign rsp_group_count = ok ? grp_ff[18:0] : '0;
   assign rsp_inodes_per_group = ok ? ipg_ff : '0;
   assign rsp_inode_table_blocks = ok ? itab[10:0] : '0;
   assign rsp_descriptor_table_blocks = ok ? gdt[13:0] : '0;
   assign rsp_total_inodes = ok ? tot : '0;
   assign rsp_free_blocks = ok ? 31'(41'(blk_ff) - 41'd1 - used_ff) : '0;
   assign rsp_reserved_blocks = ok ? rsv_ff : '0;

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("start not taken");
   a_out_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");
   a_out_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double result");
endmodule

/* design/e2lp_divider.sv */
// Restoring divider, one quotient bit per cycle, 32-bit operands.
// Uses nothing from the package.
module e2lp_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);
   logic [31:0] q_ff, q_in;
   logic [32:0] r_ff, r_in;
   logic [31:0] d_ff, d_in;
   logic [5:0]  n_ff, n_in;
   logic        run_ff, run_in;
   logic [32:0] sh;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; n_in = n_ff; run_in = run_ff;
      sh = {r_ff[31:0], q_ff[31]};
      if (go) begin
         q_in = dividend; r_in = '0; d_in = divisor; n_in = 6'd32; run_in = 1'b1;
      end else if (run_ff) begin
         if (sh >= {1'b0, d_ff}) begin
            r_in = sh - {1'b0, d_ff};
            q_in = {q_ff[30:0], 1'b1};
         end else begin
            r_in = sh;
            q_in = {q_ff[30:0], 1'b0};
         end
         n_in = n_ff - 6'd1;
         if (n_ff == 6'd1) run_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; n_ff <= n_in;
      if (reset) run_ff <= 1'b0;
      else run_ff <= run_in;
   end

   assign done = run_ff && n_ff == 6'd1;
   assign quotient = q_in;
endmodule

/* sim/tb.sv */
// Testbench for ext2_layout_planner_core: random and directed sector counts, each
// result checked field by field against a behavioral layout predictor.
// Depends on e2lp_pkg and the planner RTL.
module tb;
   localparam longint unsigned GRP_BLOCKS = 8192;
   localparam longint unsigned INODE_SZ   = 128;

   typedef struct {
      e2lp_pkg::status_type status;
      logic [30:0] total_blocks;
      logic [18:0] group_count;
      logic [13:0] inodes_per_group;
      logic [10:0] inode_table_blocks;
      logic [13:0] descriptor_table_blocks;
      logic [31:0] total_inodes;
      logic [30:0] free_blocks;
      logic [26:0] reserved_blocks;
   } layout_type;

   typedef struct {
      logic [31:0] sectors;
      bit          drain;
   } word_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [31:0] req_sector_count;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [30:0] rsp_total_blocks;
   logic [18:0] rsp_group_count;
   logic [13:0] rsp_inodes_per_group;
   logic [10:0] rsp_inode_table_blocks;
   logic [13:0] rsp_descriptor_table_blocks;
   logic [31:0] rsp_total_inodes;
   logic [30:0] rsp_free_blocks;
   logic [26:0] rsp_reserved_blocks;

   word_type   pending_words[$];
   layout_type layout_q[$];
   int      accepted_cnt = 0;
   int      sent_cnt     = 0;
   int      word_total   = 0;
   int      errors       = 0;
   int      burst_left   = 3;
   int      gap_left     = 0;

   ext2_layout_planner_core uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_sector_count(req_sector_count),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_total_blocks(rsp_total_blocks), .rsp_group_count(rsp_group_count),
      .rsp_inodes_per_group(rsp_inodes_per_group),
      .rsp_inode_table_blocks(rsp_inode_table_blocks),
      .rsp_descriptor_table_blocks(rsp_descriptor_table_blocks),
      .rsp_total_inodes(rsp_total_inodes), .rsp_free_blocks(rsp_free_blocks),
      .rsp_reserved_blocks(rsp_reserved_blocks)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // groups 0, 1 and powers of 3, 5, 7 carry a superblock copy
   function automatic bit sparse_group(input longint unsigned g);
      longint unsigned p;
      if (g <= 1) return 1'b1;
      for (int b = 3; b <= 7; b += 2) begin
         p = b;
         while (p < g) p = p * b;
         if (p == g) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic longint unsigned meta_blocks(input longint unsigned g,
                                                   input longint unsigned itab,
                                                   input longint unsigned gdt);
      return 2 + itab + (sparse_group(g) ? 1 + gdt : 0);
   endfunction

   function automatic layout_type plan_layout(input logic [31:0] sectors);
      layout_type      r;
      longint unsigned blk, grp, ino, ipg, itab, gdt, used, first, len;
      r = '{status: e2lp_pkg::STAT_OK, default: '0};
      blk = sectors / 2;
      if (blk < 64) begin
         r.status = e2lp_pkg::STAT_SMALL;
         return r;
      end
      grp = (blk - 1 + GRP_BLOCKS - 1) / GRP_BLOCKS;
      ino = blk / 16;
      if (ino < 12) ino = 12;
      ipg = (ino + grp - 1) / grp;
      ipg = (ipg + 7) / 8 * 8;
      if (ipg > 8192) ipg = 8192;
      if (ipg < 16) ipg = 16;
      itab = (ipg * INODE_SZ + 1023) / 1024;
      gdt  = (grp * 32 + 1023) / 1024;
      // drop trailing groups too short for their own metadata
      while (grp > 1) begin
         first = 1 + (grp - 1) * GRP_BLOCKS;
         len = (blk > first) ? blk - first : 0;
         if (len > GRP_BLOCKS) len = GRP_BLOCKS;
         if (len > meta_blocks(grp - 1, itab, gdt) + 1) break;
         grp--;
         blk = 1 + grp * GRP_BLOCKS;
         gdt = (grp * 32 + 1023) / 1024;
      end
      used = 2;
      for (longint unsigned g = 0; g < grp; g++) used += meta_blocks(g, itab, gdt);
      if (used + 8 >= blk) begin
         r.status = e2lp_pkg::STAT_FULL;
         return r;
      end
      r.total_blocks            = blk[30:0];
      r.group_count             = grp[18:0];
      r.inodes_per_group        = ipg[13:0];
      r.inode_table_blocks      = itab[10:0];
      r.descriptor_table_blocks = gdt[13:0];
      r.total_inodes            = 32'(ipg * grp);
      r.free_blocks             = 31'(blk - 1 - used);
      r.reserved_blocks         = 27'(blk / 20);
      return r;
   endfunction

   function automatic void add_word(input logic [31:0] s, input bit d);
      pending_words.push_back('{sectors: s, drain: d});
      word_total++;
   endfunction

   // driver: bursts of words with random gaps, changes on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_sector_count <= '0;
      end else if (start && accepted_cnt != sent_cnt) begin
         start <= 1'b1;
      end else begin
         if (start) begin
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 6);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_words.size() > 0 &&
                      !(pending_words[0].drain && layout_q.size() > 0)) begin
            start <= 1'b1;
            req_sector_count <= pending_words[0].sectors;
            void'(pending_words.pop_front());
            sent_cnt++;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: check results first, then log the newly accepted word
   always @(posedge clock) begin
      layout_type e;
      if (!reset) begin
         if (rsp_valid) begin
            if (layout_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual status %0d",
                        $time, rsp_status);
               errors++;
            end else begin
               e = layout_q.pop_front();
               if (rsp_status !== e.status) begin
                  $display("%0t: status exp %0d act %0d", $time, e.status, rsp_status);
                  errors++;
               end
               if (rsp_total_blocks !== e.total_blocks) begin
                  $display("%0t: total_blocks exp %0d act %0d", $time,
                           e.total_blocks, rsp_total_blocks);
                  errors++;
               end
               if (rsp_group_count !== e.group_count) begin
                  $display("%0t: group_count exp %0d act %0d", $time,
                           e.group_count, rsp_group_count);
                  errors++;
               end
               if (rsp_inodes_per_group !== e.inodes_per_group) begin
                  $display("%0t: inodes_per_group exp %0d act %0d", $time,
                           e.inodes_per_group, rsp_inodes_per_group);
                  errors++;
               end
               if (rsp_inode_table_blocks !== e.inode_table_blocks) begin
                  $display("%0t: inode_table_blocks exp %0d act %0d", $time,
                           e.inode_table_blocks, rsp_inode_table_blocks);
                  errors++;
               end
               if (rsp_descriptor_table_blocks !== e.descriptor_table_blocks) begin
                  $display("%0t: descriptor_table_blocks exp %0d act %0d", $time,
                           e.descriptor_table_blocks, rsp_descriptor_table_blocks);
                  errors++;
               end
               if (rsp_total_inodes !== e.total_inodes) begin
                  $display("%0t: total_inodes exp %0d act %0d", $time,
                           e.total_inodes, rsp_total_inodes);
                  errors++;
               end
               if (rsp_free_blocks !== e.free_blocks) begin
                  $display("%0t: free_blocks exp %0d act %0d", $time,
                           e.free_blocks, rsp_free_blocks);
                  errors++;
               end
               if (rsp_reserved_blocks !== e.reserved_blocks) begin
                  $display("%0t: reserved_blocks exp %0d act %0d", $time,
                           e.reserved_blocks, rsp_reserved_blocks);
                  errors++;
               end
            end
         end
         if (start && !busy) begin
            layout_q.push_back(plan_layout(req_sector_count));
            accepted_cnt++;
         end
      end
   end

   initial begin
      int r, k;
      reset = 1'b1;
      // directed: extremes, too-small edge, group boundaries and trimming
      add_word(32'd0, 1'b0);
      add_word(32'd1, 1'b0);
      add_word(32'd127, 1'b0);
      add_word(32'd128, 1'b0);
      add_word(32'd129, 1'b0);
      add_word(32'd2 * 8193, 1'b0);
      add_word(32'd2 * 8194, 1'b0);
      add_word(32'd2 * 8200, 1'b0);
      add_word(32'd2 * 8300 + 1, 1'b0);
      add_word(32'd2 * (1 + 8192 * 2) + 10, 1'b0);
      add_word(32'd2 * (1 + 8192 * 3) + 300, 1'b0);
      add_word(32'd2 * (1 + 8192 * 4), 1'b0);
      add_word(32'd2 * 16384 * 16, 1'b0);
      add_word(32'hFFFFFFFF, 1'b1);
      add_word(32'hFFFFFFFE, 1'b0);
      add_word(32'h5555_5555 >> 8, 1'b0);
      add_word(32'hAAAA_AAAA >> 8, 1'b0);
      for (int i = 0; i < 100; i++) begin
         r = $urandom_range(0, 99);
         if (r < 15) begin
            add_word($urandom_range(0, 400), i == 50);
         end else if (r < 40) begin
            k = $urandom_range(1, 60);
            add_word(2 * (1 + 8192 * k) + $urandom_range(0, 1200), i == 50);
         end else begin
            add_word($urandom_range(0, 1 << 24), i == 50);
         end
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      wait (pending_words.size() == 0 && accepted_cnt == word_total &&
            layout_q.size() == 0);
      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

   initial begin
      #40000000;
      $display("tb: FAIL");
      $finish;
   end
endmodule
